// ===== rtl/core/fbm_pkg.sv =====
// Shared widths, stage record and constants for the FFT bin magnitude unit.
`timescale 1ns / 1ps

package fbm_pkg;

   localparam int BIN_W    = 32;                 // packed bin word
   localparam int PART_W   = 16;                 // signed real / imaginary part
   localparam int SQ_W     = 31;                 // one square, at most 2^30
   localparam int POWER_W  = 32;                 // sum of squares, at most 2^31
   localparam int RAD_W    = 34;                 // radicand, 4*power for non-DC bins
   localparam int ROOT_W   = 17;                 // amplitude width
   localparam int REM_W    = ROOT_W + 1;         // remainder stays below 2*root+1
   localparam int SQRT_STEPS = RAD_W / 2;        // one root bit per stage

   localparam logic [ROOT_W-1:0] AMP_MAX = ROOT_W'(92681);

   typedef struct packed {
      logic [ROOT_W-1:0] root;
      logic [REM_W-1:0]  rem;
      logic [RAD_W-1:0]  rad;
   } sqrt_stage_type;

endpackage

// ===== rtl/core/fbm_isqrt.sv =====
// Pipelined restoring integer square root, one result bit per stage.
`timescale 1ns / 1ps

module fbm_isqrt (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  logic                               in_valid,
   input  logic [fbm_pkg::RAD_W-1:0]          in_radicand,
   output logic                               out_valid,
   output logic [fbm_pkg::ROOT_W-1:0]         out_root
);

   localparam int LAST = fbm_pkg::SQRT_STEPS - 1;
   localparam int CAT_W = fbm_pkg::REM_W + 2;

   fbm_pkg::sqrt_stage_type stage_w  [fbm_pkg::SQRT_STEPS+1];
   fbm_pkg::sqrt_stage_type stage_in [fbm_pkg::SQRT_STEPS];
   fbm_pkg::sqrt_stage_type stage_ff [fbm_pkg::SQRT_STEPS];
   logic [fbm_pkg::SQRT_STEPS-1:0] valid_ff;
   logic [fbm_pkg::SQRT_STEPS-1:0] valid_in;

   assign stage_w[0].root = '0;
   assign stage_w[0].rem  = '0;
   assign stage_w[0].rad  = in_radicand;

   assign valid_in = {valid_ff[fbm_pkg::SQRT_STEPS-2:0], in_valid};

   for (genvar k = 0; k < fbm_pkg::SQRT_STEPS; k++) begin : g_step
      logic [CAT_W-1:0] rem_cat;
      logic [CAT_W-1:0] trial;
      logic [CAT_W-1:0] diff;
      logic             take;

      // bring down the next two radicand bits, try root*4+1
      assign rem_cat = {stage_w[k].rem, stage_w[k].rad[fbm_pkg::RAD_W-1 -: 2]};
      assign trial   = {1'b0, stage_w[k].root, 2'b01};
      assign diff    = rem_cat - trial;
      assign take    = (rem_cat >= trial);

      always_comb begin
         stage_in[k].root = {stage_w[k].root[fbm_pkg::ROOT_W-2:0], take};
         stage_in[k].rem  = take ? diff[fbm_pkg::REM_W-1:0]
                                 : rem_cat[fbm_pkg::REM_W-1:0];
         stage_in[k].rad  = {stage_w[k].rad[fbm_pkg::RAD_W-3:0], 2'b00};
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            stage_ff[k] <= stage_in[k];
         end
      end

      assign stage_w[k+1] = stage_ff[k];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   assign out_valid = valid_ff[LAST];
   assign out_root  = stage_ff[LAST].root;

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(valid_ff))
      else $error("sqrt pipeline valid bits moved while held");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      valid_ff[LAST] |-> ({1'b0, stage_ff[LAST].rem} <= {stage_ff[LAST].root, 1'b0}))
      else $error("sqrt remainder exceeds 2*root");

   a_root_range: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (out_root <= fbm_pkg::AMP_MAX))
      else $error("amplitude beyond largest possible value");

endmodule

// ===== rtl/core/fft_bin_magnitude_unit.sv =====
// Top level: amplitude of one FFT output bin, floor(sqrt(p)) or floor(2*sqrt(p)).
`timescale 1ns / 1ps

// Usage
//   Request channel (req_): one beat per transform bin. req_packed_bin holds
//   the signed real part in bits 15:0 and the signed imaginary part in bits
//   31:16; req_dc_bin marks the zero-frequency bin, which is not doubled.
//   Response channel (rsp_): one beat per request, in order, carrying the
//   17-bit amplitude floor(sqrt(re^2+im^2)) for DC, floor(sqrt(4*(re^2+im^2)))
//   otherwise. Exact, never overflows (maximum 92681).
// Throughput: one beat per cycle while no finished response is held by rsp_stall.
// Pipeline: squares, then sum and scale, then 17 square-root stages that
//   each resolve one root bit with an 18/20-bit compare and subtract.
// The last square-root stage is the output register. When the receiver holds
//   rsp_stall while a response is waiting, the whole pipeline freezes and
//   req_stall is raised; nothing is lost or repeated, and empty slots keep
//   moving otherwise.
// Reset (synchronous, active high) clears every valid bit; no data state.

module fft_bin_magnitude_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [fbm_pkg::BIN_W-1:0]          req_packed_bin,
   input  logic                               req_dc_bin,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [fbm_pkg::ROOT_W-1:0]         rsp_amplitude
);

   logic advance;

   // stage 1: squares
   logic signed [fbm_pkg::PART_W-1:0]   re_part;
   logic signed [fbm_pkg::PART_W-1:0]   im_part;
   logic signed [2*fbm_pkg::PART_W-1:0] re_prod;
   logic signed [2*fbm_pkg::PART_W-1:0] im_prod;
   logic [fbm_pkg::SQ_W-1:0]            re_sq_ff;
   logic [fbm_pkg::SQ_W-1:0]            im_sq_ff;
   logic                                s1_dc_ff;
   logic                                s1_valid_ff;

   // stage 2: power and radicand
   logic [fbm_pkg::POWER_W-1:0]         power;
   logic [fbm_pkg::RAD_W-1:0]           rad_in;
   logic [fbm_pkg::RAD_W-1:0]           rad_ff;
   logic                                s2_valid_ff;

   // Freeze everything only when a finished beat waits on the receiver.
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   assign re_part = req_packed_bin[fbm_pkg::PART_W-1:0];
   assign im_part = req_packed_bin[fbm_pkg::BIN_W-1:fbm_pkg::PART_W];
   assign re_prod = re_part * re_part;
   assign im_prod = im_part * im_part;

   always_ff @(posedge clock) begin
      if (advance) begin
         re_sq_ff <= re_prod[fbm_pkg::SQ_W-1:0];   // square is at most 2^30
         im_sq_ff <= im_prod[fbm_pkg::SQ_W-1:0];
         s1_dc_ff <= req_dc_bin;
      end
   end

   // 2*sqrt(p) == sqrt(4p): scale before the root for non-DC bins
   assign power  = {1'b0, re_sq_ff} + {1'b0, im_sq_ff};
   assign rad_in = s1_dc_ff ? {2'b00, power} : {power, 2'b00};

   always_ff @(posedge clock) begin
      if (advance) begin
         rad_ff <= rad_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   fbm_isqrt u_isqrt (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (s2_valid_ff),
      .in_radicand (rad_ff),
      .out_valid   (rsp_valid),
      .out_root    (rsp_amplitude)
   );

endmodule

// ===== tb/sv/fft_bin_magnitude_unit_tb.sv =====
// Self-checking testbench for the FFT bin magnitude unit: directed and random bins.
`timescale 1ns / 1ps

// Plan
//   One request beat per bin, with an in-order queue of expected amplitudes.
//   A table of directed bins goes first: zero, the most negative and most
//   positive parts, both with and without doubling, plus a few small
//   bins. Where the amplitude is obvious it is typed into the table.
//   Every other row, and all of the random bins, is checked against
//   amplitude_of().
//   Both sides idle at random. A window in the middle of the random part
//   runs with no idling on either side, so the pipeline sees back-to-back
//   beats.
//   Handshakes are read at the falling edge. Inputs change only at the
//   rising edge, so the values read there are the ones the next rising
//   edge will act on.

module fft_bin_magnitude_unit_tb;

   localparam int  HALF_PERIOD  = 4;          // 8 ns clock
   localparam int  RESET_CYCLES = 12;
   localparam int  RANDOM_BINS  = 1600;
   localparam int  IDLE_PCT     = 36;
   localparam int  STEADY_FIRST = 700;        // random bins sent with no idling
   localparam int  STEADY_LAST  = 1000;
   localparam int  DRAIN_CYCLES = 40;         // settle time after the queue empties
   localparam int  DRAIN_LIMIT  = 5000;
   localparam int  CYCLE_LIMIT  = 200_000;    // hard stop for a hung run

   // One directed bin. Where typed is set, amp is the amplitude to expect.
   typedef struct packed {
      logic [fbm_pkg::BIN_W-1:0]  bin;
      logic                       dc;
      logic                       typed;
      logic [fbm_pkg::ROOT_W-1:0] amp;
   } bin_probe_type;

   typedef struct packed {
      logic [fbm_pkg::ROOT_W-1:0] amp;
      int unsigned                seq;
   } amp_expect_type;

   localparam int NUM_PROBES = 24;
   // Bin words are {imag, real}.
   localparam bin_probe_type PROBES [NUM_PROBES] = '{
      '{32'h0000_0000, 1'b1, 1'b1, 17'd0},      // zero bin, DC
      '{32'h0000_0000, 1'b0, 1'b1, 17'd0},      // zero bin, doubled
      '{32'h8000_8000, 1'b1, 1'b1, 17'd46340},  // both parts most negative
      '{32'h8000_8000, 1'b0, 1'b1, fbm_pkg::AMP_MAX},  // largest amplitude there is
      '{32'h0000_8000, 1'b1, 1'b1, 17'd32768},
      '{32'h0000_8000, 1'b0, 1'b1, 17'd65536},
      '{32'h8000_0000, 1'b1, 1'b1, 17'd32768},
      '{32'h8000_0000, 1'b0, 1'b1, 17'd65536},
      '{32'h0000_7FFF, 1'b1, 1'b1, 17'd32767},
      '{32'h0000_7FFF, 1'b0, 1'b1, 17'd65534},
      '{32'h7FFF_0000, 1'b1, 1'b1, 17'd32767},
      '{32'h7FFF_0000, 1'b0, 1'b1, 17'd65534},
      '{32'h7FFF_7FFF, 1'b1, 1'b1, 17'd46339},
      '{32'h7FFF_7FFF, 1'b0, 1'b0, 17'd0},
      '{32'h0004_0003, 1'b1, 1'b1, 17'd5},      // 3-4-5 triangle
      '{32'h0004_0003, 1'b0, 1'b1, 17'd10},
      '{32'hFFFC_FFFD, 1'b0, 1'b1, 17'd10},     // same, both parts negative
      '{32'h0000_0001, 1'b0, 1'b1, 17'd2},
      '{32'hFFFF_FFFF, 1'b1, 1'b0, 17'd0},
      '{32'hFFFF_FFFF, 1'b0, 1'b0, 17'd0},
      '{32'h7FFF_8000, 1'b0, 1'b0, 17'd0},      // mixed extremes
      '{32'h8000_7FFF, 1'b1, 1'b0, 17'd0},
      '{32'h1234_ABCD, 1'b0, 1'b0, 17'd0},
      '{32'h0000_0002, 1'b1, 1'b1, 17'd2}
   };

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [fbm_pkg::BIN_W-1:0]  req_packed_bin = '0;
   logic                       req_dc_bin = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [fbm_pkg::ROOT_W-1:0] rsp_amplitude;

   amp_expect_type amp_expected_q [$];
   int unsigned    mismatch_count = 0;
   int unsigned    beats_sent = 0;
   int unsigned    cycle_count = 0;
   bit             no_idle = 1'b0;     // both sides run flat out while set

   fft_bin_magnitude_unit u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_packed_bin (req_packed_bin),
      .req_dc_bin     (req_dc_bin),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_amplitude  (rsp_amplitude)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // Expected amplitude: exact floor square root of p for DC, of 4p otherwise.
   function automatic logic [fbm_pkg::ROOT_W-1:0] amplitude_of(
         input logic [fbm_pkg::BIN_W-1:0] bin, input logic dc);
      logic signed [fbm_pkg::PART_W-1:0] re_part;
      logic signed [fbm_pkg::PART_W-1:0] im_part;
      longint                            re_wide;
      longint                            im_wide;
      logic [63:0]                       rad;
      logic [63:0]                       root;
      logic [63:0]                       probe;
      re_part = bin[fbm_pkg::PART_W-1:0];
      im_part = bin[fbm_pkg::BIN_W-1:fbm_pkg::PART_W];
      re_wide = re_part;
      im_wide = im_part;
      rad     = 64'(re_wide * re_wide + im_wide * im_wide);
      if (!dc)
         rad = rad << 2;
      root  = '0;
      probe = 64'h4000_0000_0000_0000;
      while (probe > rad)
         probe = probe >> 2;
      // digit-by-digit root, one result bit per pass
      while (probe != 0) begin
         if (rad >= root + probe) begin
            rad  = rad - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root[fbm_pkg::ROOT_W-1:0];
   endfunction

   // Part values that matter most: the extremes, near zero, or anything.
   function automatic logic [fbm_pkg::PART_W-1:0] pick_part();
      logic [31:0] noise;
      noise = $urandom;
      case ($urandom_range(7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         4: return {12'h000, noise[3:0]};
         5: return 16'h0000 - {12'h000, noise[3:0]};
         default: return noise[fbm_pkg::PART_W-1:0];
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   // One request beat. Called just after a rising edge; returns just after
   // the rising edge that accepts it. The expectation is queued at the
   // falling edge where acceptance is seen.
   task automatic send_bin(input logic [fbm_pkg::BIN_W-1:0] bin, input logic dc,
                           input logic typed,
                           input logic [fbm_pkg::ROOT_W-1:0] typed_amp);
      amp_expect_type want;
      logic           took;
      while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_valid      <= 1'b0;
         req_packed_bin <= $urandom;          // noise on an idle bus
         req_dc_bin     <= 1'($urandom_range(1));
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_packed_bin <= bin;
      req_dc_bin     <= dc;
      want.amp = typed ? typed_amp : amplitude_of(bin, dc);
      want.seq = beats_sent;
      do begin
         @(negedge clock);
         took = !req_stall;
         if (took)
            amp_expected_q.push_back(want);
         @(posedge clock);
      end while (!took);
      beats_sent++;
   endtask

   // Receiver: stalls at random except inside the steady window.
   always @(posedge clock)
      rsp_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);

   // Response check, in order against the oldest expectation.
   always @(negedge clock) begin : rsp_check
      amp_expect_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (amp_expected_q.size() == 0) begin
            report_mismatch($sformatf("amplitude %0d with no bin pending", rsp_amplitude));
         end else begin
            want = amp_expected_q.pop_front();
            if (rsp_amplitude !== want.amp)
               report_mismatch($sformatf("bin %0d: amplitude %0d, expected %0d",
                                         want.seq, rsp_amplitude, want.amp));
         end
      end
   end

   // Hard stop in case the pipeline hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[%0t] timeout after %0d cycles", $time, cycle_count);
         $display("FAILURE");
         $finish;
      end
   end

   initial begin : stimulus
      logic [fbm_pkg::BIN_W-1:0] bin;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed bins
      for (int i = 0; i < NUM_PROBES; i++)
         send_bin(PROBES[i].bin, PROBES[i].dc, PROBES[i].typed, PROBES[i].amp);

      // random bins, with a stretch of back-to-back beats in the middle
      for (int i = 0; i < RANDOM_BINS; i++) begin
         no_idle = (i >= STEADY_FIRST) && (i < STEADY_LAST);
         bin = {pick_part(), pick_part()};
         send_bin(bin, 1'($urandom_range(1)), 1'b0, '0);
      end
      no_idle = 1'b0;
      req_valid <= 1'b0;

      // drain, then let the pipeline settle
      for (int n = 0; n < DRAIN_LIMIT && amp_expected_q.size() != 0; n++)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (amp_expected_q.size() != 0)
         report_mismatch($sformatf("%0d bins never answered", amp_expected_q.size()));

      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
